### rtl/cht_pkg.sv
`default_nettype none
package cht_pkg;

    localparam int CoordW   = 24;
    localparam int RadiusW  = 17;
    localparam int DiffW    = CoordW + 1;
    localparam int DenW     = 2 * DiffW + 1;
    localparam int DenMagW  = DenW - 1;
    localparam int ResW     = 32;
    localparam int QuotW    = ResW + 1;
    localparam int PreShift = 7;
    localparam int PaddrW   = 3;
    localparam int FrontStg = 4;
    localparam int DivStg   = QuotW + 2;

    localparam logic REG_OFFSET_X = 1'b0;
    localparam logic REG_OFFSET_Y = 1'b1;

    localparam logic signed [ResW-1:0] SatPos = {1'b0, {(ResW-1){1'b1}}};
    localparam logic signed [ResW-1:0] SatNeg = {1'b1, {(ResW-1){1'b0}}};

    typedef struct packed {
        logic signed [CoordW-1:0] hit_x;
        logic signed [CoordW-1:0] hit_y;
        logic [RadiusW-1:0]       drift_radius;
    } t_hit;

    typedef struct packed {
        logic signed [ResW-1:0] u_conf;
        logic signed [ResW-1:0] v_conf;
        logic signed [ResW-1:0] r_conf;
        logic                   degenerate;
    } t_conf;

    typedef struct packed {
        logic neg;
        logic zero;
        logic ovf;
    } t_lane;

endpackage
`default_nettype wire

### rtl/conformal_hit_transform.sv
`default_nettype none
// Conformal transform of detector hits. One hit transaction is accepted per
// clock while o_stall is low; results leave in order after four front stages
// (offset subtract, squares, denominator sum, magnitude), then a 33-step
// restoring divider, one quotient bit per stage for all three lanes in
// parallel, plus its saturation stage. The whole pipeline freezes while the
// output is held by i_stall. Offsets are written over the APB port at 0x0
// and 0x4 and should only change while no hit is in flight.
module conformal_hit_transform (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire cht_pkg::t_hit                 i_hit,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output cht_pkg::t_conf                     o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cht_pkg::PaddrW-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int NV = cht_pkg::FrontStg + cht_pkg::DivStg;

    logic signed [cht_pkg::CoordW-1:0] r_off_x, r_off_y;
    logic adv;
    logic [NV-1:0] r_v;

    logic signed [cht_pkg::DiffW-1:0]  r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic [cht_pkg::RadiusW-1:0]       r_r1, r_r2, r_r3;
    logic [2*cht_pkg::DiffW-1:0]       r_sx, r_sy;
    logic [2*cht_pkg::RadiusW-1:0]     r_sr;
    logic signed [cht_pkg::DenW-1:0]   r_den;
    logic [cht_pkg::DiffW-1:0]         r_ax, r_ay, r_ar;
    logic [cht_pkg::DenMagW-1:0]       r_d;
    logic                              r_nx, r_ny, r_nr;
    logic [cht_pkg::DivStg-1:0]        r_deg;

    assign pready = 1'b1;
    assign adv = !(r_v[NV-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                cht_pkg::REG_OFFSET_X: r_off_x <= pwdata[cht_pkg::CoordW-1:0];
                cht_pkg::REG_OFFSET_Y: r_off_y <= pwdata[cht_pkg::CoordW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            cht_pkg::REG_OFFSET_X: prdata = {8'h00, r_off_x};
            cht_pkg::REG_OFFSET_Y: prdata = {8'h00, r_off_y};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NV-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dx1 <= cht_pkg::DiffW'(i_hit.hit_x) - cht_pkg::DiffW'(r_off_x);
            r_dy1 <= cht_pkg::DiffW'(i_hit.hit_y) - cht_pkg::DiffW'(r_off_y);
            r_r1  <= i_hit.drift_radius;

            r_sx  <= unsigned'((2*cht_pkg::DiffW)'(r_dx1) * (2*cht_pkg::DiffW)'(r_dx1));
            r_sy  <= unsigned'((2*cht_pkg::DiffW)'(r_dy1) * (2*cht_pkg::DiffW)'(r_dy1));
            r_sr  <= r_r1 * r_r1;
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            r_r2  <= r_r1;

            r_den <= signed'({1'b0, r_sx} + {1'b0, r_sy}
                     - {{(cht_pkg::DenW - 2*cht_pkg::RadiusW){1'b0}}, r_sr});
            r_dx3 <= r_dx2;
            r_dy3 <= r_dy2;
            r_r3  <= r_r2;

            r_d   <= r_den[cht_pkg::DenW-1] ? cht_pkg::DenMagW'(-r_den)
                                            : r_den[cht_pkg::DenMagW-1:0];
            r_ax  <= r_dx3[cht_pkg::DiffW-1] ? unsigned'(-r_dx3) : unsigned'(r_dx3);
            r_ay  <= r_dy3[cht_pkg::DiffW-1] ? unsigned'(-r_dy3) : unsigned'(r_dy3);
            r_ar  <= {{(cht_pkg::DiffW - cht_pkg::RadiusW){1'b0}}, r_r3};
            r_nx  <= r_dx3[cht_pkg::DiffW-1] != r_den[cht_pkg::DenW-1];
            r_ny  <= r_dy3[cht_pkg::DiffW-1] != r_den[cht_pkg::DenW-1];
            r_nr  <= r_den[cht_pkg::DenW-1];

            r_deg <= {r_deg[cht_pkg::DivStg-2:0], (r_d == '0)};
        end
    end

    cht_divider u_div_u (
        .i_clk (i_clk), .i_en (adv), .i_a (r_ax), .i_d (r_d), .i_neg (r_nx),
        .o_q   (o_res.u_conf)
    );

    cht_divider u_div_v (
        .i_clk (i_clk), .i_en (adv), .i_a (r_ay), .i_d (r_d), .i_neg (r_ny),
        .o_q   (o_res.v_conf)
    );

    cht_divider u_div_r (
        .i_clk (i_clk), .i_en (adv), .i_a (r_ar), .i_d (r_d), .i_neg (r_nr),
        .o_q   (o_res.r_conf)
    );

    assign o_res.degenerate = r_deg[cht_pkg::DivStg-1];
    assign o_valid = r_v[NV-1];

`ifndef NO_ASSERTIONS
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall not tied to output hold");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid survived reset");
    a_deg_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.degenerate |->
        (o_res.r_conf == '0 || o_res.r_conf == cht_pkg::SatPos))
        else $error("degenerate radius not saturated");
    a_deg_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.degenerate |->
        (o_res.u_conf == '0 || o_res.u_conf == cht_pkg::SatPos ||
         o_res.u_conf == cht_pkg::SatNeg))
        else $error("degenerate u not saturated");
`endif

endmodule
`default_nettype wire

### rtl/cht_divider.sv
`default_nettype none
module cht_divider (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [cht_pkg::DiffW-1:0]           i_a,
    input  wire logic [cht_pkg::DenMagW-1:0]         i_d,
    input  wire logic                                i_neg,
    output logic signed [cht_pkg::ResW-1:0]          o_q
);

    localparam int NS = cht_pkg::QuotW;

    logic [cht_pkg::DenMagW-1:0] r_rem [0:NS];
    logic [cht_pkg::DenMagW-1:0] r_d   [0:NS];
    logic [cht_pkg::QuotW-1:0]   r_q   [0:NS];
    cht_pkg::t_lane              r_fl  [0:NS];
    logic signed [cht_pkg::ResW-1:0] r_out;

    logic [cht_pkg::DenMagW-1:0] n_rem0;
    logic [cht_pkg::DenMagW-1:0] n_rem [1:NS];
    logic [cht_pkg::QuotW-1:0]   n_q   [1:NS];
    logic signed [cht_pkg::ResW-1:0] n_out;

    assign n_rem0 = {{(cht_pkg::DenMagW - cht_pkg::DiffW - cht_pkg::PreShift){1'b0}},
                     i_a, {cht_pkg::PreShift{1'b0}}};

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            logic [cht_pkg::DenMagW+1:0] diff;
            diff = {1'b0, r_rem[i], 1'b0} - {2'b00, r_d[i]};
            if (diff[cht_pkg::DenMagW+1]) begin
                n_rem[i+1] = {r_rem[i][cht_pkg::DenMagW-2:0], 1'b0};
                n_q[i+1]   = {r_q[i][cht_pkg::QuotW-2:0], 1'b0};
            end else begin
                n_rem[i+1] = diff[cht_pkg::DenMagW-1:0];
                n_q[i+1]   = {r_q[i][cht_pkg::QuotW-2:0], 1'b1};
            end
        end
    end

    always_comb begin
        logic [cht_pkg::QuotW-1:0] q;
        q = r_q[NS];
        priority if (r_fl[NS].zero) begin
            n_out = '0;
        end else if (r_fl[NS].ovf) begin
            n_out = r_fl[NS].neg ? cht_pkg::SatNeg : cht_pkg::SatPos;
        end else if (r_fl[NS].neg) begin
            if (q >= {2'b01, {(cht_pkg::ResW-1){1'b0}}}) n_out = cht_pkg::SatNeg;
            else n_out = -$signed(q[cht_pkg::ResW-1:0]);
        end else begin
            if (q > {2'b00, {(cht_pkg::ResW-1){1'b1}}}) n_out = cht_pkg::SatPos;
            else n_out = $signed(q[cht_pkg::ResW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= n_rem0;
            r_d[0]       <= i_d;
            r_q[0]       <= '0;
            r_fl[0].neg  <= i_neg;
            r_fl[0].zero <= (i_a == '0);
            r_fl[0].ovf  <= (n_rem0 >= i_d);
            for (int i = 1; i <= NS; i++) begin
                r_rem[i] <= n_rem[i];
                r_d[i]   <= r_d[i-1];
                r_q[i]   <= n_q[i];
                r_fl[i]  <= r_fl[i-1];
            end
            r_out <= n_out;
        end
    end

    assign o_q = r_out;

endmodule
`default_nettype wire
